@@ design/sat_axis_sweep_triangle_unit_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the separating-axis sweep unit
// Shared concurrent assertion forms, clocked on the rising edge and disabled
// while reset is high.
// ----------------------------------------------------------------------------
`ifndef SAT_AXIS_SWEEP_TRIANGLE_UNIT_MACROS_SVH
`define SAT_AXIS_SWEEP_TRIANGLE_UNIT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SAST_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SAST_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ design/sast_pkg.sv @@
// ----------------------------------------------------------------------------
// sast_pkg
// Shared types and constants of the separating-axis sweep unit.
// ----------------------------------------------------------------------------
`default_nettype none

package sast_pkg;

   localparam int TIME_W     = 32;
   localparam int THR_W      = 16;
   localparam int RADIUS_W   = 31;
   localparam int CSR_IDX_W  = 2;
   localparam int QUOT_BITS  = 33;
   localparam int QUOT_CNT_W = 6;
   localparam int SAT_SHIFT  = 17;
   localparam int FRAC_OUT   = 16;

   localparam logic signed [TIME_W-1:0] TIME_ONE = 32'sd65536;
   localparam logic [THR_W-1:0] THR_RESET = 16'd1;

   localparam logic [CSR_IDX_W-1:0] CSR_TIME_START = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_TIME_END   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_STILL_THR  = 2'd2;

   localparam logic [1:0] MODE_MOVING_BOX    = 2'd0;
   localparam logic [1:0] MODE_MOVING_SPHERE = 2'd1;

   typedef struct packed {
      logic start;
      logic moving;
      logic overlap;
   } sast_ctl_type;

endpackage

`default_nettype wire

@@ design/sast_fifo.sv @@
// ----------------------------------------------------------------------------
// sast_fifo
// Two-entry queue between the classifying front end and the time back end.
// ----------------------------------------------------------------------------
`default_nettype none

module sast_fifo #(
   parameter int W = 8
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         push,
   input  wire logic [W-1:0] wdata,
   output logic              full,
   input  wire logic         pop,
   output logic [W-1:0]      rdata,
   output logic              empty
);

   logic [W-1:0] mem_ff [2];
   logic         wr_ptr_ff, wr_ptr_in;
   logic         rd_ptr_ff, rd_ptr_in;
   logic [1:0]   count_ff, count_in;
   logic         do_push, do_pop;

   assign full    = (count_ff == 2'd2);
   assign empty   = (count_ff == 2'd0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign rdata   = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 2'd1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= wdata;
      end
   end

endmodule

`default_nettype wire

@@ design/sast_front.sv @@
// ----------------------------------------------------------------------------
// sast_front
// Accepts an item, projects the shape and triangle onto the axis and
// classifies it as static, still or moving before queuing it.
// ----------------------------------------------------------------------------
`default_nettype none

module sast_front #(
   parameter int CB     = 16,
   parameter int DW     = 34,
   parameter int RW     = 36,
   parameter int NW     = 39,
   parameter int DOT_UP = 0,
   parameter int Q16_UP = 0
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          push,
   output logic                               full,
   input  wire logic [1:0]                    mode,
   input  wire logic                          start_query,
   input  wire logic [3*CB-1:0]               test_axis,
   input  wire logic [3*CB-1:0]               shape_center,
   input  wire logic [3*CB-1:0]               box_axis_a,
   input  wire logic [3*CB-1:0]               box_axis_b,
   input  wire logic [3*CB-1:0]               box_axis_c,
   input  wire logic [sast_pkg::RADIUS_W-1:0] sphere_radius,
   input  wire logic [3*CB-1:0]               motion,
   input  wire logic [3*CB-1:0]               corner_one,
   input  wire logic [3*CB-1:0]               corner_two,
   input  wire logic [3*CB-1:0]               corner_three,
   input  wire logic [sast_pkg::THR_W-1:0]    still_threshold,
   output logic                               q_push,
   input  wire logic                          q_full,
   output sast_pkg::sast_ctl_type             q_ctl,
   output logic signed [NW-1:0]               q_num_a,
   output logic signed [NW-1:0]               q_num_b,
   output logic signed [DW-1:0]               q_delta
);

   localparam int VW = 3 * CB;
   localparam int NV = 8;
   localparam int PW = 2 * CB;
   localparam int CW = (DW + 1 > sast_pkg::THR_W + 1 + Q16_UP) ?
                       DW + 1 : sast_pkg::THR_W + 1 + Q16_UP;

   typedef enum logic [4:0] {
      F_IDLE = 5'b00001,
      F_MUL  = 5'b00010,
      F_SUM  = 5'b00100,
      F_EXT  = 5'b01000,
      F_PUSH = 5'b10000
   } front_state_type;

   front_state_type state_ff, state_in;

   logic [VW-1:0]                    vec_in [NV];
   logic [VW-1:0]                    vec_ff [NV];
   logic [VW-1:0]                    axis_ff;
   logic [1:0]                       mode_ff;
   logic                             start_ff;
   logic [sast_pkg::RADIUS_W-1:0]    radius_ff;
   logic signed [PW-1:0]             prod_ff [NV][3];
   logic signed [DW-1:0]             dot_ff [NV];
   logic signed [DW-1:0]             dot_sum [NV];
   logic signed [RW-1:0]             rad_in, rad_ff;
   logic signed [RW-1:0]             mag_a, mag_b, mag_c;
   logic signed [DW-1:0]             tlo_in, thi_in, tlo_ff, thi_ff;
   logic signed [DW-1:0]             c_ff, delta_ff;
   logic signed [CW-1:0]             delta_mag, thr_ext;
   logic                             moving_in, moving_ff;
   logic signed [NW-1:0]             lo0, hi0;
   logic                             accept;

   assign full   = (state_ff != F_IDLE);
   assign accept = push && (state_ff == F_IDLE);

   always_comb begin
      vec_in[0] = shape_center;
      vec_in[1] = box_axis_a;
      vec_in[2] = box_axis_b;
      vec_in[3] = box_axis_c;
      vec_in[4] = motion;
      vec_in[5] = corner_one;
      vec_in[6] = corner_two;
      vec_in[7] = corner_three;
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         F_IDLE: begin
            if (push) begin
               state_in = F_MUL;
            end
         end
         F_MUL:  state_in = F_SUM;
         F_SUM:  state_in = F_EXT;
         F_EXT:  state_in = F_PUSH;
         F_PUSH: begin
            if (!q_full) begin
               state_in = F_IDLE;
            end
         end
         default: state_in = F_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         for (int i = 0; i < NV; i++) begin
            vec_ff[i] <= vec_in[i];
         end
         axis_ff   <= test_axis;
         mode_ff   <= mode;
         start_ff  <= start_query;
         radius_ff <= sphere_radius;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == F_MUL) begin
         for (int i = 0; i < NV; i++) begin
            for (int k = 0; k < 3; k++) begin
               prod_ff[i][k] <= $signed(vec_ff[i][k*CB +: CB]) *
                                $signed(axis_ff[k*CB +: CB]);
            end
         end
      end
   end

   always_comb begin
      for (int i = 0; i < NV; i++) begin
         dot_sum[i] = (DW'(prod_ff[i][0]) + DW'(prod_ff[i][1]) + DW'(prod_ff[i][2]))
                      <<< DOT_UP;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == F_SUM) begin
         for (int i = 0; i < NV; i++) begin
            dot_ff[i] <= dot_sum[i];
         end
      end
   end

   always_comb begin
      mag_a = (dot_ff[1] < 0) ? -RW'(dot_ff[1]) : RW'(dot_ff[1]);
      mag_b = (dot_ff[2] < 0) ? -RW'(dot_ff[2]) : RW'(dot_ff[2]);
      mag_c = (dot_ff[3] < 0) ? -RW'(dot_ff[3]) : RW'(dot_ff[3]);
      if (mode_ff == sast_pkg::MODE_MOVING_SPHERE) begin
         rad_in = $signed(RW'(radius_ff)) <<< Q16_UP;
      end else begin
         rad_in = mag_a + mag_b + mag_c;
      end
      tlo_in = dot_ff[5];
      thi_in = dot_ff[5];
      for (int i = 6; i < NV; i++) begin
         if (dot_ff[i] < tlo_in) begin
            tlo_in = dot_ff[i];
         end
         if (dot_ff[i] > thi_in) begin
            thi_in = dot_ff[i];
         end
      end
      delta_mag = (dot_ff[4] < 0) ? -CW'(dot_ff[4]) : CW'(dot_ff[4]);
      thr_ext   = $signed(CW'(still_threshold)) <<< Q16_UP;
      moving_in = (mode_ff == sast_pkg::MODE_MOVING_BOX ||
                   mode_ff == sast_pkg::MODE_MOVING_SPHERE) &&
                  (dot_ff[4] != '0) && (delta_mag >= thr_ext);
   end

   always_ff @(posedge clock) begin
      if (state_ff == F_EXT) begin
         rad_ff    <= rad_in;
         tlo_ff    <= tlo_in;
         thi_ff    <= thi_in;
         c_ff      <= dot_ff[0];
         delta_ff  <= dot_ff[4];
         moving_ff <= moving_in;
      end
   end

   always_comb begin
      lo0           = NW'(c_ff) - NW'(rad_ff);
      hi0           = NW'(c_ff) + NW'(rad_ff);
      q_push        = (state_ff == F_PUSH);
      q_ctl.start   = start_ff;
      q_ctl.moving  = moving_ff;
      q_ctl.overlap = moving_ff || !((lo0 > NW'(thi_ff)) || (NW'(tlo_ff) > hi0));
      q_num_a       = NW'(tlo_ff) - hi0;
      q_num_b       = NW'(thi_ff) - lo0;
      q_delta       = delta_ff;
   end

endmodule

`default_nettype wire

@@ design/sast_div.sv @@
// ----------------------------------------------------------------------------
// sast_div
// Radix-2 restoring divider giving a saturated Q16.16 quotient, truncated
// toward zero, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module sast_div #(
   parameter int NW = 39,
   parameter int DW = 34
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               go,
   input  wire logic signed [NW-1:0]               num,
   input  wire logic signed [DW-1:0]               den,
   output logic                                    done,
   output logic signed [sast_pkg::TIME_W-1:0]      quot
);

   localparam int QB = sast_pkg::QUOT_BITS;
   localparam int SW = NW + DW + sast_pkg::SAT_SHIFT;

   logic                               busy_ff;
   logic                               done_ff;
   logic [sast_pkg::QUOT_CNT_W-1:0]    cnt_ff;
   logic [DW-1:0]                      rem_ff;
   logic [DW-1:0]                      ud_ff;
   logic [QB-1:0]                      quo_ff;
   logic [QB-1:0]                      bits_ff;
   logic                               neg_ff;
   logic                               sat_ff;
   logic [NW-1:0]                      un;
   logic [DW-1:0]                      ud;
   logic [SW-1:0]                      un_wide;
   logic [DW:0]                        shifted;
   logic [DW:0]                        diff;
   logic                               qbit;
   logic [QB-1:0]                      limit;
   logic [QB-1:0]                      qmag;
   logic [QB-1:0]                      qsigned;

   always_comb begin
      un      = num[NW-1] ? NW'(-num) : NW'(num);
      ud      = den[DW-1] ? DW'(-den) : DW'(den);
      un_wide = SW'(un);
      shifted = {rem_ff, bits_ff[QB-1]};
      diff    = shifted - {1'b0, ud_ff};
      qbit    = (shifted >= {1'b0, ud_ff});
      limit   = neg_ff ? (QB'(1) << 31) : ((QB'(1) << 31) - QB'(1));
      if (sat_ff || quo_ff > limit) begin
         qmag = limit;
      end else begin
         qmag = quo_ff;
      end
      qsigned = neg_ff ? -qmag : qmag;
      quot    = qsigned[sast_pkg::TIME_W-1:0];
      done    = done_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (go) begin
            busy_ff <= 1'b1;
            cnt_ff  <= sast_pkg::QUOT_CNT_W'(QB);
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - sast_pkg::QUOT_CNT_W'(1);
            if (cnt_ff == sast_pkg::QUOT_CNT_W'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (go) begin
         ud_ff   <= ud;
         neg_ff  <= num[NW-1] ^ den[DW-1];
         sat_ff  <= (un_wide >= (SW'(ud) << sast_pkg::SAT_SHIFT));
         rem_ff  <= DW'(un_wide >> sast_pkg::SAT_SHIFT);
         bits_ff <= {un[sast_pkg::SAT_SHIFT-1:0], {sast_pkg::FRAC_OUT{1'b0}}};
         quo_ff  <= '0;
      end else if (busy_ff) begin
         rem_ff  <= qbit ? diff[DW-1:0] : shifted[DW-1:0];
         bits_ff <= {bits_ff[QB-2:0], 1'b0};
         quo_ff  <= {quo_ff[QB-2:0], qbit};
      end
   end

endmodule

`default_nettype wire

@@ design/sast_back.sv @@
// ----------------------------------------------------------------------------
// sast_back
// Takes classified items from the queue, divides the interval gaps by the
// velocity projection and narrows the running entry and exit times.
// ----------------------------------------------------------------------------
`default_nettype none
`include "sat_axis_sweep_triangle_unit_macros.svh"

module sast_back #(
   parameter int NW = 39,
   parameter int DW = 34
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 q_empty,
   output logic                                      q_pop,
   input  wire sast_pkg::sast_ctl_type               q_ctl,
   input  wire logic signed [NW-1:0]                 q_num_a,
   input  wire logic signed [NW-1:0]                 q_num_b,
   input  wire logic signed [DW-1:0]                 q_delta,
   input  wire logic signed [sast_pkg::TIME_W-1:0]   time_start,
   input  wire logic signed [sast_pkg::TIME_W-1:0]   time_end,
   output logic                                      rsp_empty,
   input  wire logic                                 rsp_pop,
   output logic                                      rsp_intervals_overlap,
   output logic signed [sast_pkg::TIME_W-1:0]        rsp_entry_time,
   output logic signed [sast_pkg::TIME_W-1:0]        rsp_exit_time,
   output logic                                      rsp_entry_axis_hit,
   output logic                                      rsp_exit_axis_hit
);

   typedef enum logic [2:0] {
      B_IDLE = 3'b001,
      B_DIV  = 3'b010,
      B_FIN  = 3'b100
   } back_state_type;

   back_state_type state_ff, state_in;

   sast_pkg::sast_ctl_type                rec_ctl_ff;
   logic signed [sast_pkg::TIME_W-1:0]    entry_ff, exit_ff;
   logic signed [sast_pkg::TIME_W-1:0]    t_a, t_b, tmin, tmax;
   logic signed [sast_pkg::TIME_W-1:0]    entry_new, exit_new;
   logic                                  ehit, xhit;
   logic                                  done_a, done_b;
   logic                                  div_go;
   logic                                  out_valid_ff;
   logic                                  out_free;
   logic                                  finish;

   assign out_free  = !out_valid_ff || rsp_pop;
   assign q_pop     = (state_ff == B_IDLE) && !q_empty;
   assign div_go    = q_pop && q_ctl.moving;
   assign finish    = (state_ff == B_FIN) && out_free;
   assign rsp_empty = !out_valid_ff;

   sast_div #(.NW(NW), .DW(DW)) u_div_a (
      .clock (clock),
      .reset (reset),
      .go    (div_go),
      .num   (q_num_a),
      .den   (q_delta),
      .done  (done_a),
      .quot  (t_a)
   );

   sast_div #(.NW(NW), .DW(DW)) u_div_b (
      .clock (clock),
      .reset (reset),
      .go    (div_go),
      .num   (q_num_b),
      .den   (q_delta),
      .done  (done_b),
      .quot  (t_b)
   );

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         B_IDLE: begin
            if (!q_empty) begin
               state_in = q_ctl.moving ? B_DIV : B_FIN;
            end
         end
         B_DIV: begin
            if (done_a && done_b) begin
               state_in = B_FIN;
            end
         end
         B_FIN: begin
            if (out_free) begin
               state_in = B_IDLE;
            end
         end
         default: state_in = B_IDLE;
      endcase
   end

   always_comb begin
      tmin      = (t_a < t_b) ? t_a : t_b;
      tmax      = (t_a < t_b) ? t_b : t_a;
      ehit      = rec_ctl_ff.moving && (tmin > entry_ff);
      xhit      = rec_ctl_ff.moving && (tmax < exit_ff);
      entry_new = ehit ? tmin : entry_ff;
      exit_new  = xhit ? tmax : exit_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_IDLE;
         out_valid_ff <= 1'b0;
         entry_ff     <= '0;
         exit_ff      <= sast_pkg::TIME_ONE;
      end else begin
         state_ff <= state_in;
         if (q_pop && q_ctl.start) begin
            entry_ff <= time_start;
            exit_ff  <= time_end;
         end else if (finish) begin
            entry_ff <= entry_new;
            exit_ff  <= exit_new;
         end
         if (finish) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_pop) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         rec_ctl_ff <= q_ctl;
      end
      if (finish) begin
         rsp_intervals_overlap <= rec_ctl_ff.overlap;
         rsp_entry_time        <= entry_new;
         rsp_exit_time         <= exit_new;
         rsp_entry_axis_hit    <= ehit;
         rsp_exit_axis_hit     <= xhit;
      end
   end

   `SAST_ASSERT_SAME(a_div_only_moving, clock, reset, state_ff == B_DIV, rec_ctl_ff.moving, "division started for an item that is not moving")
   `SAST_ASSERT_NEXT(a_fin_holds, clock, reset, (state_ff == B_FIN) && !out_free, state_ff == B_FIN, "result left before the output slot was free")
   `SAST_ASSERT_NEXT(a_still_no_hit, clock, reset, finish && !rec_ctl_ff.moving, !rsp_entry_axis_hit && !rsp_exit_axis_hit, "contact axis flagged for a still or static item")

endmodule

`default_nettype wire

@@ design/sat_axis_sweep_triangle_unit.sv @@
// ----------------------------------------------------------------------------
// sat_axis_sweep_triangle_unit
// One separating-axis step of a triangle against a box or sphere, static or
// swept, with running entry and exit times.
//
//   Channel   Handshake          Moves
//   req_      push / full        one axis test item
//   rsp_      empty / pop        overlap flag, running times, hit flags
//   csr_      write              time_start, time_end, still_threshold
//
// The front end takes an item through capture, multiply, dot sums, extents and
// hand-off to the two-entry queue, and takes no new item until the hand-off.
// The back end takes a static or still item straight to B_FIN; a swept one
// first waits on the 33-step radix-2 dividers (one quotient bit a cycle).
// Synchronous reset; no clearing pass, items are taken right after reset.
// A stalled result holds the back end; the front runs on till the queue fills.
// ----------------------------------------------------------------------------
`default_nettype none

module sat_axis_sweep_triangle_unit #(
   parameter int COMPONENT_BITS = 16,
   parameter int FRACTION_BITS  = 8
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_push,
   output logic                                      req_full,
   input  wire logic [1:0]                           req_mode,
   input  wire logic                                 req_start_query,
   input  wire logic [3*COMPONENT_BITS-1:0]          req_test_axis,
   input  wire logic [3*COMPONENT_BITS-1:0]          req_shape_center,
   input  wire logic [3*COMPONENT_BITS-1:0]          req_box_axis_a,
   input  wire logic [3*COMPONENT_BITS-1:0]          req_box_axis_b,
   input  wire logic [3*COMPONENT_BITS-1:0]          req_box_axis_c,
   input  wire logic [sast_pkg::RADIUS_W-1:0]        req_sphere_radius,
   input  wire logic [3*COMPONENT_BITS-1:0]          req_motion,
   input  wire logic [3*COMPONENT_BITS-1:0]          req_corner_one,
   input  wire logic [3*COMPONENT_BITS-1:0]          req_corner_two,
   input  wire logic [3*COMPONENT_BITS-1:0]          req_corner_three,
   output logic                                      rsp_empty,
   input  wire logic                                 rsp_pop,
   output logic                                      rsp_intervals_overlap,
   output logic signed [sast_pkg::TIME_W-1:0]        rsp_entry_time,
   output logic signed [sast_pkg::TIME_W-1:0]        rsp_exit_time,
   output logic                                      rsp_entry_axis_hit,
   output logic                                      rsp_exit_axis_hit,
   input  wire logic                                 csr_write,
   input  wire logic [sast_pkg::CSR_IDX_W-1:0]       csr_index,
   input  wire logic [sast_pkg::TIME_W-1:0]          csr_data
);

   localparam int INNER  = (2 * FRACTION_BITS > 16) ? 2 * FRACTION_BITS : 16;
   localparam int DOT_UP = INNER - 2 * FRACTION_BITS;
   localparam int Q16_UP = INNER - 16;
   localparam int DW     = 2 * COMPONENT_BITS + 2 + DOT_UP;
   localparam int RW     = (DW + 2 > 32 + Q16_UP) ? DW + 2 : 32 + Q16_UP;
   localparam int NW     = RW + 3;
   localparam int CTL_W  = $bits(sast_pkg::sast_ctl_type);
   localparam int QW     = CTL_W + 2 * NW + DW;

   logic signed [sast_pkg::TIME_W-1:0]    time_start_ff;
   logic signed [sast_pkg::TIME_W-1:0]    time_end_ff;
   logic [sast_pkg::THR_W-1:0]            still_thr_ff;

   logic                                  f_push, q_full, q_empty, b_pop;
   sast_pkg::sast_ctl_type                f_ctl, b_ctl;
   logic signed [NW-1:0]                  f_num_a, f_num_b, b_num_a, b_num_b;
   logic signed [DW-1:0]                  f_delta, b_delta;
   logic [QW-1:0]                         q_wdata, q_rdata;

   always_ff @(posedge clock) begin
      if (reset) begin
         time_start_ff <= '0;
         time_end_ff   <= sast_pkg::TIME_ONE;
         still_thr_ff  <= sast_pkg::THR_RESET;
      end else if (csr_write) begin
         unique case (csr_index)
            sast_pkg::CSR_TIME_START: time_start_ff <= csr_data;
            sast_pkg::CSR_TIME_END:   time_end_ff   <= csr_data;
            sast_pkg::CSR_STILL_THR:  still_thr_ff  <= csr_data[sast_pkg::THR_W-1:0];
            default: ;
         endcase
      end
   end

   sast_front #(
      .CB     (COMPONENT_BITS),
      .DW     (DW),
      .RW     (RW),
      .NW     (NW),
      .DOT_UP (DOT_UP),
      .Q16_UP (Q16_UP)
   ) u_front (
      .clock           (clock),
      .reset           (reset),
      .push            (req_push),
      .full            (req_full),
      .mode            (req_mode),
      .start_query     (req_start_query),
      .test_axis       (req_test_axis),
      .shape_center    (req_shape_center),
      .box_axis_a      (req_box_axis_a),
      .box_axis_b      (req_box_axis_b),
      .box_axis_c      (req_box_axis_c),
      .sphere_radius   (req_sphere_radius),
      .motion          (req_motion),
      .corner_one      (req_corner_one),
      .corner_two      (req_corner_two),
      .corner_three    (req_corner_three),
      .still_threshold (still_thr_ff),
      .q_push          (f_push),
      .q_full          (q_full),
      .q_ctl           (f_ctl),
      .q_num_a         (f_num_a),
      .q_num_b         (f_num_b),
      .q_delta         (f_delta)
   );

   assign q_wdata = {f_ctl, f_num_a, f_num_b, f_delta};

   sast_fifo #(.W(QW)) u_queue (
      .clock (clock),
      .reset (reset),
      .push  (f_push),
      .wdata (q_wdata),
      .full  (q_full),
      .pop   (b_pop),
      .rdata (q_rdata),
      .empty (q_empty)
   );

   always_comb begin
      b_ctl   = sast_pkg::sast_ctl_type'(q_rdata[QW-1 -: CTL_W]);
      b_num_a = $signed(q_rdata[2*NW+DW-1 -: NW]);
      b_num_b = $signed(q_rdata[NW+DW-1 -: NW]);
      b_delta = $signed(q_rdata[DW-1:0]);
   end

   sast_back #(.NW(NW), .DW(DW)) u_back (
      .clock                 (clock),
      .reset                 (reset),
      .q_empty               (q_empty),
      .q_pop                 (b_pop),
      .q_ctl                 (b_ctl),
      .q_num_a               (b_num_a),
      .q_num_b               (b_num_b),
      .q_delta               (b_delta),
      .time_start            (time_start_ff),
      .time_end              (time_end_ff),
      .rsp_empty             (rsp_empty),
      .rsp_pop               (rsp_pop),
      .rsp_intervals_overlap (rsp_intervals_overlap),
      .rsp_entry_time        (rsp_entry_time),
      .rsp_exit_time         (rsp_exit_time),
      .rsp_entry_axis_hit    (rsp_entry_axis_hit),
      .rsp_exit_axis_hit     (rsp_exit_axis_hit)
   );

endmodule

`default_nettype wire
